// ----- rtl/sspd_pkg.sv -----
// ----------------------------------------------------------------------------
// sspd_pkg
// Shared types and constants for the servo status packet deframer.
// ----------------------------------------------------------------------------
package sspd_pkg;

  localparam int unsigned BUFFER_BYTES = 32;
  localparam int unsigned CNT_W        = $clog2(BUFFER_BYTES + 1);

  localparam logic [7:0]  HEADER_MARK   = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd300;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    REQ_ARM  = 2'd0,
    REQ_BYTE = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

endpackage

// ----- rtl/servo_status_packet_deframer_top.sv -----
// Output: a result beat is registered and presented in the cycle after the
// byte or tick beat that completes the packet or the timeout.
// Throughput: one input beat per cycle; the input stalls only while a result
// beat waits in the output register.
// Reset: asynchronous, active low; receiver idle, timeout register back to 300.
// ----------------------------------------------------------------------------
// servo_status_packet_deframer_top
// Receives status packets (FF FF, ID, LEN, ERR, params, checksum) byte by
// byte, verifies the checksum and reports ok, checksum mismatch or timeout.
// ----------------------------------------------------------------------------
module servo_status_packet_deframer_top
  import sspd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i,      // timeout_ticks
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // rx_byte
  input  logic [1:0]            s_axis_tuser_i,  // req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // servo_id, error_byte, param_count, first_param, second_param, overflow
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]            m_axis_tuser_o   // status
);

  logic [15:0]      timeout_q;
  logic             listening_q, listening_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             header_ok_q, header_ok_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       err_q, err_d;
  logic [7:0]       par0_q, par0_d;
  logic [7:0]       par1_q, par1_d;
  logic [7:0]       sum_q, sum_d;
  logic [15:0]      tick_q, tick_d;
  logic             dropped_q, dropped_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [1:0]            out_user_q, out_user_d;

  logic             take;
  req_e             req;
  logic [7:0]       b;
  logic [9:0]       p_ext;
  logic [7:0]       len_now;
  logic [7:0]       err_now;
  logic [7:0]       pcount;
  logic [15:0]      tick_inc;

  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign req             = req_e'(s_axis_tuser_i);
  assign b               = s_axis_tdata_i;
  assign p_ext           = 10'(count_q);
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign len_now         = (count_q == CNT_W'(3)) ? b : len_q;
  assign err_now         = (count_q == CNT_W'(4)) ? b : err_q;
  assign pcount          = (len_now >= 8'd2) ? (len_now - 8'd2) : 8'd0;
  assign tick_inc        = (tick_q != TICK_MAX) ? (tick_q + 16'd1) : tick_q;

  always_comb begin
    listening_d = listening_q;
    count_d     = count_q;
    header_ok_d = header_ok_q;
    id_d        = id_q;
    len_d       = len_q;
    err_d       = err_q;
    par0_d      = par0_q;
    par1_d      = par1_q;
    sum_d       = sum_q;
    tick_d      = tick_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    if (take) begin
      case (req)
        REQ_ARM: begin
          listening_d = 1'b1;
          count_d     = '0;
          header_ok_d = 1'b0;
          id_d        = 8'd0;
          len_d       = 8'd0;
          err_d       = 8'd0;
          par0_d      = 8'd0;
          par1_d      = 8'd0;
          sum_d       = 8'd0;
          tick_d      = 16'd0;
          dropped_d   = 1'b0;
        end
        REQ_BYTE: begin
          if (listening_q) begin
            if (p_ext >= 10'(BUFFER_BYTES)) begin
              dropped_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
              if (count_q == CNT_W'(0)) begin
                header_ok_d = (b == HEADER_MARK);
              end else if (count_q == CNT_W'(1)) begin
                header_ok_d = header_ok_q && (b == HEADER_MARK);
              end
              if (count_q == CNT_W'(2)) id_d = b;
              len_d = len_now;
              err_d = err_now;
              if (p_ext >= 10'd2 && p_ext <= 10'(len_now) + 10'd2) begin
                sum_d = sum_q + b;
                if (count_q == CNT_W'(5)) par0_d = b;
                if (count_q == CNT_W'(6)) par1_d = b;
              end
              if (header_ok_q && p_ext >= 10'd3 && p_ext == 10'(len_now) + 10'd3) begin
                listening_d = 1'b0;
                out_valid_d = 1'b1;
                out_user_d  = (~sum_q == b) ? ST_OK : ST_CHECKSUM;
                out_data_d  = {7'd0, dropped_q, par1_q, par0_q, pcount, err_now, id_q};
              end
            end
          end
        end
        REQ_TICK: begin
          if (listening_q) begin
            tick_d = tick_inc;
            if (tick_inc >= timeout_q) begin
              listening_d = 1'b0;
              out_valid_d = 1'b1;
              out_user_d  = ST_TIMEOUT;
              out_data_d  = {7'd0, dropped_q, 40'd0};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      listening_q <= 1'b0;
      count_q     <= '0;
      header_ok_q <= 1'b0;
      id_q        <= 8'd0;
      len_q       <= 8'd0;
      err_q       <= 8'd0;
      par0_q      <= 8'd0;
      par1_q      <= 8'd0;
      sum_q       <= 8'd0;
      tick_q      <= 16'd0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) timeout_q <= cfg_data_i;
      listening_q <= listening_d;
      count_q     <= count_d;
      header_ok_q <= header_ok_d;
      id_q        <= id_d;
      len_q       <= len_d;
      err_q       <= err_d;
      par0_q      <= par0_d;
      par1_q      <= par1_d;
      sum_q       <= sum_d;
      tick_q      <= tick_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- rtl/sspd_checker.sv -----
// ----------------------------------------------------------------------------
// sspd_checker
// Port-level checks for the servo status packet deframer.
// ----------------------------------------------------------------------------
module sspd_checker
  import sspd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]            m_axis_tuser_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while result beat stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != ST_UNUSED)
    else $error("invalid status code");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_TIMEOUT |-> m_axis_tdata_o[39:0] == 40'd0)
    else $error("timeout beat carries packet fields");

  a_param_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[23:16] <= 8'd253)
    else $error("parameter count out of range");

endmodule

bind servo_status_packet_deframer_top sspd_checker u_sspd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
